// ===== hw/rtl/fir29_sample_framer_defines.svh =====
// Assertion helpers used by fir29_sample_framer.sv.
`ifndef FIR29_SAMPLE_FRAMER_DEFINES_SVH
`define FIR29_SAMPLE_FRAMER_DEFINES_SVH

// Checked on every rising edge, quiet while reset is asserted.
`define FSF_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Checked on every rising edge, reset included.
`define FSF_ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hw/rtl/fsf_pkg.sv =====
`timescale 1ns / 1ps

package fsf_pkg;

	localparam int ORDER = 28;
	localparam int DEPTH = ORDER + 1;
	localparam int PTR_W = $clog2(DEPTH + 1);
	localparam int ADDR_W = $clog2(DEPTH);
	localparam int SUM_W = 16;

	localparam logic [7:0] FLAG_BIT    = 8'h40;
	localparam logic [7:0] MID_TAG     = 8'h80;
	localparam logic [7:0] LAST_TAG    = 8'hC0;
	localparam logic [7:0] BYPASS_LAST = 8'h80;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_MAC,
		ST_LAST,
		ST_DONE
	} state_t;

	// symmetric low-pass taps; taps past the table are zero
	function automatic logic signed [7:0] coef(input logic [ADDR_W-1:0] tap);
		logic signed [7:0] c;
		c = 8'sd0;
		case (tap)
			5'd1, 5'd27:  c = 8'sd1;
			5'd3, 5'd25:  c = -8'sd1;
			5'd5, 5'd23:  c = 8'sd3;
			5'd7, 5'd21:  c = -8'sd6;
			5'd9, 5'd19:  c = 8'sd12;
			5'd11, 5'd17: c = -8'sd24;
			5'd13, 5'd15: c = 8'sd80;
			5'd14:        c = 8'sd127;
			default:      c = 8'sd0;
		endcase
		return c;
	endfunction

endpackage

// ===== hw/rtl/fir29_sample_framer.sv =====
`timescale 1ns / 1ps
// fir29_sample_framer: 29-tap FIR on 8-bit converter samples, framed as three bytes.
// Input channel: in_valid / in_stall carry sample, flag_one and flag_two; one beat
// per sample. Output channel: out_valid / out_stall carry frame_byte and last_byte;
// three beats per sample, last_byte set on the third.
// Configuration: cfg_we writes cfg_wdata into filter_enable (reset 1); write only
// while the block is idle.
// Filter mode: the sample is written into a 29-entry delay line memory, then one
// shared multiply-accumulate walks the taps, one memory read per cycle. The frame
// is loaded once the 29 tap reads, the registered read of the last tap and the
// frame hand-off are through; only then is a new sample taken.
// Bypass mode: the raw sample is framed; with an open receiver the next sample is
// held back only by the three output beats and the frame load.
// The frame sits in an output register, so the next sample is taken and filtered
// while the previous frame drains; a stalled receiver holds the current byte, and
// a finished sum waits until the output register is free.
// Reset: the delay line reads as zero (per-entry valid bits cleared), the write
// pointer restarts so the first sample lands in the last entry, filter mode on.
`include "fir29_sample_framer_defines.svh"

module fir29_sample_framer (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] sample,
	input  logic       flag_one,
	input  logic       flag_two,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] frame_byte,
	output logic       last_byte,
	input  logic       cfg_we,
	input  logic       cfg_wdata
);

	localparam int AW = fsf_pkg::ADDR_W;
	localparam int PW = fsf_pkg::PTR_W;
	localparam int SW = fsf_pkg::SUM_W;

	fsf_pkg::state_t state_q, state_nxt;

	logic          filter_en_q;
	logic          mode_q;
	logic [7:0]    smp_q;
	logic          f1_q, f2_q;
	logic [PW-1:0] ptr_q, ptr_nxt;
	logic [AW-1:0] tap_q;
	logic [SW-1:0] acc_q;

	logic [7:0]              line_mem_q [fsf_pkg::DEPTH];
	logic [fsf_pkg::DEPTH-1:0] vld_q;
	logic [7:0]    rd_data_s1;
	logic          rd_vld_s1;
	logic          rd_go_s1;
	logic [AW-1:0] tap_s1;

	logic [7:0] fb0_q, fb1_q, fb2_q;
	logic       busy_q;
	logic [1:0] sel_q;

	logic          in_acc, out_acc;
	logic          mem_we, rd_go, load_frame;
	logic [AW:0]   addr_sum;
	logic [AW-1:0] rd_addr, wr_addr;
	logic [7:0]    mac_data;
	logic signed [16:0] prod;
	logic [7:0] b0, b1, b2;

	assign in_acc  = in_valid && !in_stall;
	assign out_acc = out_valid && !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			filter_en_q <= 1'b1;
		end else if (cfg_we) begin
			filter_en_q <= cfg_wdata;
		end
	end

	// pointer counts down, wrapping (or recovering from the reset value) to ORDER
	always_comb begin
		if (ptr_q == '0 || ptr_q > PW'(fsf_pkg::ORDER)) begin
			ptr_nxt = PW'(fsf_pkg::ORDER);
		end else begin
			ptr_nxt = ptr_q - 1'b1;
		end
	end
	assign wr_addr = ptr_nxt[AW-1:0];

	always_comb begin
		addr_sum = {1'b0, ptr_q[AW-1:0]} + {1'b0, tap_q};
		if (addr_sum > (AW+1)'(fsf_pkg::ORDER)) begin
			rd_addr = AW'(addr_sum - (AW+1)'(fsf_pkg::DEPTH));
		end else begin
			rd_addr = addr_sum[AW-1:0];
		end
	end

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			fsf_pkg::ST_IDLE: begin
				if (in_valid) begin
					state_nxt = filter_en_q ? fsf_pkg::ST_MAC : fsf_pkg::ST_DONE;
				end
			end
			fsf_pkg::ST_MAC: begin
				if (tap_q == AW'(fsf_pkg::ORDER)) begin
					state_nxt = fsf_pkg::ST_LAST;
				end
			end
			fsf_pkg::ST_LAST: state_nxt = fsf_pkg::ST_DONE;
			fsf_pkg::ST_DONE: begin
				if (!busy_q) begin
					state_nxt = fsf_pkg::ST_IDLE;
				end
			end
			default: state_nxt = fsf_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		in_stall   = 1'b1;
		mem_we     = 1'b0;
		rd_go      = 1'b0;
		load_frame = 1'b0;
		unique case (state_q)
			fsf_pkg::ST_IDLE: begin
				in_stall = 1'b0;
				mem_we   = in_valid && filter_en_q;
			end
			fsf_pkg::ST_MAC:  rd_go = 1'b1;
			fsf_pkg::ST_LAST: ;
			fsf_pkg::ST_DONE: load_frame = !busy_q;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= fsf_pkg::ST_IDLE;
			ptr_q    <= PW'(fsf_pkg::DEPTH);
			vld_q    <= '0;
			rd_go_s1 <= 1'b0;
		end else begin
			state_q  <= state_nxt;
			rd_go_s1 <= rd_go;
			if (mem_we) begin
				ptr_q            <= ptr_nxt;
				vld_q[wr_addr]   <= 1'b1;
			end
		end
	end

	// delay line memory: one write at a filter-mode accept, one registered read per tap
	always_ff @(posedge clk) begin
		if (mem_we) begin
			line_mem_q[wr_addr] <= sample;
		end
		rd_data_s1 <= line_mem_q[rd_addr];
		rd_vld_s1  <= vld_q[rd_addr];
		tap_s1     <= tap_q;
	end

	assign mac_data = rd_vld_s1 ? rd_data_s1 : 8'h00;
	assign prod = $signed({1'b0, mac_data}) * fsf_pkg::coef(tap_s1);

	always_ff @(posedge clk) begin
		if (in_acc) begin
			smp_q  <= sample;
			f1_q   <= flag_one;
			f2_q   <= flag_two;
			mode_q <= filter_en_q;
			acc_q  <= '0;
			tap_q  <= '0;
		end else begin
			if (rd_go) begin
				tap_q <= tap_q + 1'b1;
			end
			if (rd_go_s1) begin
				acc_q <= acc_q + prod[SW-1:0];
			end
		end
	end

	always_comb begin
		if (mode_q) begin
			b0 = (f1_q ? fsf_pkg::FLAG_BIT : 8'h00) | {2'b00, acc_q[15:10]};
			b1 = fsf_pkg::MID_TAG | (f2_q ? fsf_pkg::FLAG_BIT : 8'h00)
				| {2'b00, acc_q[9:4]};
			b2 = fsf_pkg::LAST_TAG | {4'h0, acc_q[3:0]};
		end else begin
			b0 = (f1_q ? fsf_pkg::FLAG_BIT : 8'h00) | {2'b00, smp_q[7:2]};
			b1 = fsf_pkg::MID_TAG | (f2_q ? fsf_pkg::FLAG_BIT : 8'h00)
				| {6'b000000, smp_q[1:0]};
			b2 = fsf_pkg::BYPASS_LAST;
		end
	end

	always_ff @(posedge clk) begin
		if (load_frame) begin
			fb0_q <= b0;
			fb1_q <= b1;
			fb2_q <= b2;
		end
	end

	// advance one byte per output beat, drop the frame after the third
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			sel_q  <= '0;
		end else if (load_frame) begin
			busy_q <= 1'b1;
			sel_q  <= '0;
		end else if (out_acc) begin
			if (sel_q == 2'd2) begin
				busy_q <= 1'b0;
				sel_q  <= '0;
			end else begin
				sel_q <= sel_q + 1'b1;
			end
		end
	end

	assign out_valid = busy_q;
	assign last_byte = (sel_q == 2'd2);

	always_comb begin
		case (sel_q)
			2'd0:    frame_byte = fb0_q;
			2'd1:    frame_byte = fb1_q;
			default: frame_byte = fb2_q;
		endcase
	end

	`FSF_ASSERT(a_busy_after_accept, in_acc |=> in_stall, "input accepted while busy")
	`FSF_ASSERT(a_frame_ends, (out_acc && last_byte) |=> !out_valid, "frame ran past three beats")
	`FSF_ASSERT(a_sel_range, busy_q |-> (sel_q != 2'd3), "byte select out of range")
	`FSF_ASSERT(a_read_in_line, rd_go |-> (rd_addr <= AW'(fsf_pkg::ORDER)), "tap read outside delay line")
	`FSF_ASSERT_ALWAYS(a_mac_window, rd_go_s1 |-> (state_q == fsf_pkg::ST_MAC || state_q == fsf_pkg::ST_LAST), "accumulate outside tap walk")

endmodule
